/* src/lfae_pkg.sv */
// shared types and constants for the led fade engine
package lfae_pkg;

    localparam int CHANNEL_COUNT_DEF = 8;
    localparam int US_PER_TICK_DEF   = 1000;
    localparam int LVL_W   = 8;
    localparam int HCT_W   = 26;
    localparam int ELAP_W  = 32;
    localparam int CH_W    = 3;
    localparam logic [LVL_W-1:0] LVL_MAX = 8'd255;

    localparam logic [1:0] ACT_TICK      = 2'd0;
    localparam logic [1:0] ACT_SET_ANIM  = 2'd1;
    localparam logic [1:0] ACT_SET_LEVEL = 2'd2;
    localparam logic [1:0] ACT_SET_IDLE  = 2'd3;

    localparam logic [0:0] REG_MUTE = 1'd0;
    localparam logic [0:0] REG_DIM  = 1'd1;

    typedef struct packed {
        logic [1:0]  action;
        logic [2:0]  channel;
        logic [7:0]  from_level;
        logic [7:0]  to_level;
        logic [7:0]  half_cycles;
        logic [15:0] duration_ms;
        logic [15:0] tick_count;
        logic        apply_now;
    } lfae_in_t;

    typedef struct packed {
        logic [2:0] out_channel;
        logic [7:0] drive_level;
        logic       any_animating;
        logic       last;
    } lfae_out_t;

    // one channel record held in the state memory
    typedef struct packed {
        logic [LVL_W-1:0]  cur;
        logic [LVL_W-1:0]  src;
        logic [LVL_W-1:0]  tgt;
        logic [LVL_W-1:0]  idle;
        logic [LVL_W-1:0]  halves;
        logic [ELAP_W-1:0] elapsed;
        logic [HCT_W-1:0]  hct;
        logic              back;
    } lfae_chan_t;

    // divider handshake
    typedef struct packed {
        logic              start;
        logic [ELAP_W+7:0] num;
        logic [HCT_W-1:0]  den;
    } lfae_div_req_t;

    typedef struct packed {
        logic              done;
        logic [ELAP_W+7:0] quot;
    } lfae_div_rsp_t;

endpackage

/* src/led_fade_animation_engine.sv */
// led fade engine: top level with the sequencer over the channel memory
// a set command reads and rewrites its channel record; a tick visits every channel
// (40-step shared divider for animating ones), then, unless muted or nothing is pending, reports one result per channel
// throughput: one request at a time; the next is taken only in idle with no result pending
// reset: aresetn synchronous active low; a clearing pass writes one channel
// per cycle through all CHANNEL_COUNT channels after reset, no request taken meanwhile
module led_fade_animation_engine
    import lfae_pkg::*;
#(
    parameter int CHANNEL_COUNT = CHANNEL_COUNT_DEF,
    parameter int MICROSECONDS_PER_TICK = US_PER_TICK_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  lfae_in_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output lfae_out_t   m_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:2]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int AW = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
    localparam int TICK_SCALE = 1000 / MICROSECONDS_PER_TICK;
    localparam int TSW = $clog2(TICK_SCALE + 1);
    localparam int NW = ELAP_W + 8;

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_SRD   = 4'd2;
    localparam logic [3:0] ST_SWR   = 4'd3;
    localparam logic [3:0] ST_TRD   = 4'd4;
    localparam logic [3:0] ST_TCHK  = 4'd5;
    localparam logic [3:0] ST_TDIV  = 4'd6;
    localparam logic [3:0] ST_TMUL  = 4'd7;
    localparam logic [3:0] ST_TWR   = 4'd8;
    localparam logic [3:0] ST_ORD   = 4'd9;
    localparam logic [3:0] ST_OWAIT = 4'd10;
    localparam logic [3:0] ST_OOUT  = 4'd11;

    logic [3:0]    state_reg, state_next;
    logic [AW-1:0] ch_reg, ch_next;
    lfae_in_t      req_reg, req_next;
    logic          mute_reg, mute_next;
    logic          dim_reg, dim_next;
    logic          pend_reg, pend_next;
    logic          any_reg, any_next;
    logic [7:0]    frac_reg, frac_next;
    logic          ended_reg, ended_next;
    lfae_chan_t    rec_reg, rec_next;
    logic [16:0]   pa_reg, pa_next;
    logic [16:0]   pb_reg, pb_next;
    logic          mval_reg, mval_next;
    lfae_out_t     mdat_reg, mdat_next;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    lfae_chan_t    wdata, rdata;
    lfae_div_req_t dreq;
    lfae_div_rsp_t drsp;

    logic          cfg_wr;
    logic          ch_ok;
    logic [HCT_W-1:0] hct_new;
    logic [NW-1:0] num;
    logic [32:0]   el_sum;
    logic [7:0]    q8;
    logic [7:0]    halves_new;
    logic [LVL_W-1:0] lvl_new;

    lfae_mem #(.CHANNEL_COUNT(CHANNEL_COUNT)) u_mem (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    lfae_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (dreq),
        .rsp     (drsp)
    );

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_DIM) ? {31'd0, dim_reg} : {31'd0, mute_reg};
    assign s_ready = (state_reg == ST_IDLE) && !mval_reg;
    assign m_valid = mval_reg;
    assign m_data  = mdat_reg;

    assign ch_ok   = ({3'b0, req_reg.channel} < 6'(CHANNEL_COUNT));
    assign hct_new = HCT_W'(req_reg.duration_ms * TSW'(TICK_SCALE));
    assign num     = {8'd0, rec_reg.elapsed} * 40'd255;
    assign q8      = drsp.quot[7:0];
    assign el_sum  = {1'b0, rec_reg.elapsed} + {17'd0, req_reg.tick_count};
    assign halves_new = rec_reg.halves - {7'd0, ended_reg};

    always_comb begin
        lvl_new = 8'((pa_reg + pb_reg) >> 8);
    end

    always_comb begin
        state_next = state_reg;
        ch_next    = ch_reg;
        req_next   = req_reg;
        mute_next  = mute_reg;
        dim_next   = dim_reg;
        pend_next  = pend_reg;
        any_next   = any_reg;
        frac_next  = frac_reg;
        ended_next = ended_reg;
        rec_next   = rec_reg;
        pa_next    = pa_reg;
        pb_next    = pb_reg;
        mval_next  = mval_reg;
        mdat_next  = mdat_reg;
        we    = 1'b0;
        waddr = ch_reg;
        wdata = rec_reg;
        raddr = ch_reg;
        dreq.start = 1'b0;
        dreq.num   = num;
        dreq.den   = rec_reg.hct;

        if (mval_reg && m_ready) begin
            mval_next = 1'b0;
        end
        if (cfg_wr) begin
            if (paddr[2] == REG_MUTE) begin
                mute_next = pwdata[0];
                pend_next = 1'b1;
            end else begin
                dim_next = pwdata[0];
            end
        end

        unique case (state_reg)
            ST_CLEAR: begin
                we    = 1'b1;
                wdata = '0;
                ch_next = ch_reg + 1'b1;
                if (ch_reg == AW'(CHANNEL_COUNT - 1)) begin
                    ch_next    = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    req_next = s_data;
                    if (s_data.action == ACT_TICK) begin
                        ch_next    = '0;
                        any_next   = 1'b0;
                        state_next = ST_TRD;
                    end else begin
                        ch_next    = AW'(s_data.channel);
                        state_next = ST_SRD;
                    end
                end
            end
            ST_SRD: begin
                raddr      = ch_reg;
                state_next = ST_SWR;
                if (!ch_ok) begin
                    state_next = ST_IDLE;
                end
            end
            ST_SWR: begin
                wdata = rdata;
                we    = 1'b1;
                pend_next = 1'b1;
                case (req_reg.action)
                    ACT_SET_ANIM: begin
                        wdata.src     = req_reg.from_level;
                        wdata.tgt     = req_reg.to_level;
                        wdata.halves  = req_reg.half_cycles;
                        wdata.idle    = req_reg.half_cycles[0] ? req_reg.to_level
                                                               : req_reg.from_level;
                        wdata.hct     = hct_new;
                        wdata.elapsed = '0;
                        wdata.back    = 1'b0;
                    end
                    ACT_SET_LEVEL: begin
                        if (req_reg.duration_ms == 16'd0) begin
                            wdata.halves = '0;
                            wdata.idle   = req_reg.to_level;
                            wdata.cur    = req_reg.to_level;
                        end else begin
                            wdata.src     = rdata.cur;
                            wdata.tgt     = req_reg.to_level;
                            wdata.halves  = 8'd1;
                            wdata.idle    = req_reg.to_level;
                            wdata.hct     = hct_new;
                            wdata.elapsed = '0;
                            wdata.back    = 1'b0;
                        end
                    end
                    default: begin
                        wdata.idle = req_reg.to_level;
                        if (req_reg.apply_now) begin
                            wdata.cur = req_reg.to_level;
                        end
                    end
                endcase
                state_next = ST_IDLE;
            end
            ST_TRD: begin
                raddr      = ch_reg;
                state_next = ST_TCHK;
            end
            ST_TCHK: begin
                rec_next = rdata;
                if (rdata.halves == 8'd0) begin
                    state_next = ST_TWR;
                end else begin
                    any_next  = 1'b1;
                    pend_next = 1'b1;
                    if (rdata.hct == '0) begin
                        ended_next = 1'b1;
                        state_next = ST_TMUL;
                        if (rdata.back) begin
                            frac_next = 8'd0;
                        end else begin
                            frac_next = LVL_MAX;
                        end
                    end else begin
                        state_next = ST_TDIV;
                    end
                end
            end
            ST_TDIV: begin
                // wait for the quotient
                if (drsp.done) begin
                    if (drsp.quot > NW'(255)) begin
                        ended_next = 1'b1;
                        frac_next  = rec_reg.back ? 8'd0 : LVL_MAX;
                    end else begin
                        ended_next = 1'b0;
                        frac_next  = rec_reg.back ? LVL_MAX - q8 : q8;
                    end
                    state_next = ST_TMUL;
                end
            end
            ST_TMUL: begin
                pa_next = 17'(rec_reg.src) * (17'd256 - {9'd0, frac_reg});
                pb_next = 17'(rec_reg.tgt * frac_reg);
                if (ended_reg) begin
                    rec_next.back    = !rec_reg.back;
                    rec_next.elapsed = '0;
                end
                state_next = ST_TWR;
            end
            ST_TWR: begin
                wdata = rec_reg;
                if (rec_reg.halves != 8'd0) begin
                    we = 1'b1;
                    wdata.halves = halves_new;
                    if (halves_new == 8'd0) begin
                        wdata.cur = rec_reg.idle;
                    end else begin
                        wdata.elapsed = el_sum[32] ? '1 : el_sum[31:0];
                        wdata.cur     = lvl_new;
                    end
                end
                ended_next = 1'b0;
                ch_next    = ch_reg + 1'b1;
                state_next = ST_TRD;
                if (ch_reg == AW'(CHANNEL_COUNT - 1)) begin
                    ch_next    = '0;
                    state_next = ST_ORD;
                    if (!(pend_reg || rec_reg.halves != 8'd0) || mute_next) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_ORD: begin
                raddr      = ch_reg;
                state_next = ST_OWAIT;
            end
            ST_OWAIT: begin
                rec_next   = rdata;
                state_next = ST_OOUT;
            end
            ST_OOUT: begin
                if (!mval_reg || m_ready) begin
                    mval_next = 1'b1;
                    mdat_next.out_channel   = 3'(ch_reg);
                    mdat_next.drive_level   = dim_reg ? {1'b0, rec_reg.cur[7:1]}
                                                      : rec_reg.cur;
                    mdat_next.any_animating = any_reg;
                    mdat_next.last          = (ch_reg == AW'(CHANNEL_COUNT - 1));
                    ch_next    = ch_reg + 1'b1;
                    state_next = ST_ORD;
                    if (ch_reg == AW'(CHANNEL_COUNT - 1)) begin
                        ch_next    = '0;
                        pend_next  = cfg_wr && (paddr[2] == REG_MUTE);
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase

        // launch the divider on entry to the divide state
        if (state_reg == ST_TCHK && state_next == ST_TDIV) begin
            dreq.start = 1'b1;
            dreq.num   = {8'd0, rdata.elapsed} * 40'd255;
            dreq.den   = rdata.hct;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            ch_reg    <= '0;
            mute_reg  <= 1'b0;
            dim_reg   <= 1'b0;
            pend_reg  <= 1'b0;
            any_reg   <= 1'b0;
            ended_reg <= 1'b0;
            mval_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            ch_reg    <= ch_next;
            mute_reg  <= mute_next;
            dim_reg   <= dim_next;
            pend_reg  <= pend_next;
            any_reg   <= any_next;
            ended_reg <= ended_next;
            mval_reg  <= mval_next;
        end
        req_reg  <= req_next;
        frac_reg <= frac_next;
        rec_reg  <= rec_next;
        pa_reg   <= pa_next;
        pb_reg   <= pb_next;
        mdat_reg <= mdat_next;
    end

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_ready)
        else $error("request taken while busy");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("result dropped under stall");
    a_no_write_output: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OOUT) |-> !we)
        else $error("memory written during report");
`endif

endmodule

/* src/lfae_div.sv */
// radix-2 restoring divider, one quotient bit per cycle
module lfae_div
    import lfae_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  lfae_div_req_t req,
    output lfae_div_rsp_t rsp
);
    localparam int NW = ELAP_W + 8;
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0]  quot_reg, quot_next;
    logic [HCT_W:0] rem_reg, rem_next;
    logic [HCT_W-1:0] den_reg, den_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           busy_reg, busy_next;
    logic           done_reg, done_next;
    logic [HCT_W:0] trial;

    always_comb begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[HCT_W-1:0], quot_reg[NW-1]};
        if (req.start) begin
            quot_next = req.num;
            rem_next  = '0;
            den_next  = req.den;
            cnt_next  = CW'(NW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, den_reg}) begin
                rem_next  = trial - {1'b0, den_reg};
                quot_next = {quot_reg[NW-2:0], 1'b1};
            end else begin
                rem_next  = trial;
                quot_next = {quot_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

/* src/lfae_mem.sv */
// channel state memory, one write and one registered read port
module lfae_mem
    import lfae_pkg::*;
#(
    parameter int CHANNEL_COUNT = CHANNEL_COUNT_DEF
) (
    input  logic                                                      aclk,
    input  logic                                                      we,
    input  logic [((CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1)-1:0] waddr,
    input  lfae_chan_t                                                wdata,
    input  logic [((CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1)-1:0] raddr,
    output lfae_chan_t                                                rdata
);
    lfae_chan_t mem [CHANNEL_COUNT];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
